[rtl/bdq_pkg.sv]
// Shared types, constants and helpers for the bounded deque block.
package bdq_pkg;

  // Storage geometry
  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = PTR_W + 1;

  // Port field widths
  localparam int CMD_W = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int ST_W  = 3;
  localparam int LEN_W = 5;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_READ_POS   = 3'd4,
    CMD_REVERSE    = 3'd5
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_BADPOS = 3'd3,
    ST_ZERO   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [VAL_W-1:0] item_value;
    logic [POS_W-1:0] position;
  } in_word_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] result_value;
    logic [LEN_W-1:0] length;
  } out_word_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;
    logic execute;
    logic load_out;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  // (base + off) mod DEPTH, both operands below DEPTH
  function automatic logic [PTR_W-1:0] slot_wrap(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

[rtl/bdq_ctrl.sv]
// Sequencing state machine for the bounded deque: accept, execute, respond.
module bdq_ctrl import bdq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_RESP;
      S_RESP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd.capture  = 1'b0;
    cmd.execute  = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_EXEC: cmd.execute = 1'b1;
      S_RESP: cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/bdq_dpath.sv]
// Deque datapath: ring store, front pointer, count, orientation, output word.
module bdq_dpath import bdq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  // captured input word
  logic [CMD_W-1:0]      cmd_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [POS_W-1:0]      pos_r;

  // deque state
  logic [PTR_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             rev_r, rev_nxt;

  // pending result
  logic [ST_W-1:0]       status_r, status_nxt;
  logic                  has_val_r, has_val_nxt;
  logic [VALUE_BITS-1:0] rd_data_r;

  // output register
  logic      out_valid_r;
  out_word_t out_word_r;

  logic [VALUE_BITS-1:0] mem [DEPTH];

  logic             wr_en;
  logic [PTR_W-1:0] wr_addr, rd_addr, rd_off;
  logic [PTR_W-1:0] front_dec, front_inc, cnt_lo, cnt_m1, pos_m1;
  logic [CMP_W-1:0] pos_ext, cnt_ext;
  logic             at_back, phys_end;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_data.command;
      val_r <= VALUE_BITS'(in_data.item_value);
      pos_r <= in_data.position;
    end
  end

  assign front_dec = (front_r == '0) ? PTR_W'(DEPTH - 1) : front_r - PTR_W'(1);
  assign front_inc = (front_r == PTR_W'(DEPTH - 1)) ? '0 : front_r + PTR_W'(1);
  assign cnt_lo    = count_r[PTR_W-1:0];
  assign cnt_m1    = PTR_W'(count_r - CNT_W'(1));
  assign pos_m1    = PTR_W'(pos_r - POS_W'(1));
  assign pos_ext   = CMP_W'(pos_r);
  assign cnt_ext   = CMP_W'(count_r);

  always_comb begin
    front_nxt   = front_r;
    count_nxt   = count_r;
    rev_nxt     = rev_r;
    status_nxt  = ST_OK;
    has_val_nxt = 1'b0;
    wr_en       = 1'b0;
    rd_off      = '0;
    at_back     = (cmd_r == CMD_PUSH_BACK) || (cmd_r == CMD_POP_BACK);
    phys_end    = at_back != rev_r;
    unique case (cmd_r)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (val_r == '0) begin
          status_nxt = ST_ZERO;
        end else if (count_r == CNT_W'(DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          if (!phys_end) front_nxt = front_dec;
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          has_val_nxt = 1'b1;
          count_nxt   = count_r - CNT_W'(1);
          if (phys_end) begin
            rd_off = cnt_m1;
          end else begin
            rd_off    = '0;
            front_nxt = front_inc;
          end
        end
      end
      CMD_READ_POS: begin
        if (pos_r == '0 || pos_ext > cnt_ext) begin
          status_nxt = ST_BADPOS;
        end else begin
          has_val_nxt = 1'b1;
          rd_off      = rev_r ? (cnt_m1 - pos_m1) : pos_m1;
        end
      end
      CMD_REVERSE: rev_nxt = !rev_r;
      default: ;
    endcase
  end

  assign rd_addr = slot_wrap(front_r, rd_off);
  assign wr_addr = phys_end ? slot_wrap(front_r, cnt_lo) : front_dec;

  always_ff @(posedge clk) begin
    if (cmd.execute && wr_en) begin
      mem[wr_addr] <= val_r;
    end
    if (cmd.execute) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (cmd.execute) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status_r  <= status_nxt;
      has_val_r <= has_val_nxt;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word_r.status       <= status_r;
      out_word_r.result_value <= has_val_r ? VAL_W'(rd_data_r) : '0;
      out_word_r.length       <= LEN_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

[rtl/bounded_deque_with_index_reverse_top.sv]
// Top level of the bounded deque: controller plus datapath, with checks.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+----------------------------------------
//  in_     | input     | in_valid/in_stall  | command, item_value, position
//  out_    | output    | out_valid/out_stall| status, result_value, length
//
// Each command passes through an accept step that takes the word, an execute
// step that runs the op against the ring store (pointer update, store write,
// registered store read), and a respond step that loads the output register
// once the result side is free.
// Reset (rst_n low, synchronous) empties the deque and clears orientation;
// store contents are left as they are and are never read before written.
// A stalled result holds in the output register; a new word is still taken
// while it waits, and that word's result waits in the respond step.
module bounded_deque_with_index_reverse_top import bdq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  bdq_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // one word in flight: after acceptance the input side stalls
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a word was in flight");

  // length never exceeds the store depth
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.length <= LEN_W'(DEPTH))
    else $error("reported length above depth");

  // failed commands return no handle
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.result_value == '0)
    else $error("nonzero value on failed command");

  // empty status only when nothing is held
  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.length == '0)
    else $error("empty status with entries held");

endmodule

[dv/bounded_deque_with_index_reverse_top_test.sv]
// Self-checking testbench for the bounded deque: random/directed words, predictor, scoreboard.
module bounded_deque_with_index_reverse_top_test;
  import bdq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Command codes the package enum leaves out; the block treats them as no-ops.
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  localparam int RAND_ITEMS = 1600;
  localparam int IDLE_PCT   = 20;
  // Cycle window in which neither side idles, so back-to-back traffic is seen.
  localparam int CALM_FROM  = 1500;
  localparam int CALM_TO    = 3000;
  localparam int TAIL_WAIT  = 16;
  localparam int MAX_PRINTS = 200;

  // Random burst shapes: push-heavy, pop-heavy, balanced.
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  typedef struct {
    bit       hold;   // sender waits for the deque to settle before this word
    in_word_t word;
  } pending_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  bounded_deque_with_index_reverse_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  pending_t  cmd_backlog[$];     // words waiting for the driver
  out_word_t expected_words[$];  // predicted results, oldest first
  int        fail_count;
  int        cyc;
  bit        word_taken;         // the word on the bus was accepted at the last edge
  int        gen_len;            // length as seen while building stimulus
  out_word_t got_word;
  out_word_t want_word;

  // Predictor state: ring store, physical front slot, entry count, orientation.
  logic [VAL_W-1:0] ring_vals [DEPTH];
  int               head_slot;
  int               held;
  bit               flipped;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    if (fail_count <= MAX_PRINTS) begin
      $display("%0t ns  %s: got %0h, want %0h", $time, what, got, want);
    end
  endtask

  // Applies one accepted word to the predictor state and returns its result.
  function automatic out_word_t deque_predict(input in_word_t w);
    out_word_t r;
    bit        at_tail;
    int        k;
    r.status       = ST_OK;
    r.result_value = '0;
    case (w.command)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        // zero handle is refused ahead of the full check
        if (w.item_value == '0) begin
          r.status = ST_ZERO;
        end else if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          at_tail = (w.command == CMD_PUSH_BACK) != flipped;
          if (at_tail) begin
            ring_vals[PTR_W'((head_slot + held) % DEPTH)] = w.item_value;
          end else begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            ring_vals[PTR_W'(head_slot)] = w.item_value;
          end
          held++;
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          at_tail = (w.command == CMD_POP_BACK) != flipped;
          held--;
          if (at_tail) begin
            r.result_value = ring_vals[PTR_W'((head_slot + held) % DEPTH)];
          end else begin
            r.result_value = ring_vals[PTR_W'(head_slot)];
            head_slot = (head_slot + 1) % DEPTH;
          end
        end
      end
      CMD_READ_POS: begin
        if (w.position < 1 || int'(w.position) > held) begin
          r.status = ST_BADPOS;
        end else begin
          // position counts from the logical front
          k = flipped ? held - int'(w.position) : int'(w.position) - 1;
          r.result_value = ring_vals[PTR_W'((head_slot + k) % DEPTH)];
        end
      end
      CMD_REVERSE: begin
        flipped = !flipped;
      end
      default: begin
      end
    endcase
    r.length = LEN_W'(held);
    return r;
  endfunction

  // Queues a word for the driver and keeps the stimulus-side length in step.
  task automatic queue_word(input logic [CMD_W-1:0] c, input logic [VAL_W-1:0] v,
                            input logic [POS_W-1:0] p, input bit hold);
    pending_t pw;
    pw.hold             = hold;
    pw.word.command     = c;
    pw.word.item_value  = v;
    pw.word.position    = p;
    cmd_backlog.push_back(pw);
    if ((c == CMD_PUSH_BACK || c == CMD_PUSH_FRONT) && v != '0 && gen_len < DEPTH) begin
      gen_len++;
    end else if ((c == CMD_POP_BACK || c == CMD_POP_FRONT) && gen_len > 0) begin
      gen_len--;
    end
  endtask

  function automatic bit calm_window();
    return cyc >= CALM_FROM && cyc < CALM_TO;
  endfunction

  // Input driver: changes on the falling edge, holds a word until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (cmd_backlog.size() != 0 &&
          !(cmd_backlog[0].hold && expected_words.size() != 0) &&
          (calm_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_data  <= cmd_backlog[0].word;
        in_valid <= 1'b1;
        cmd_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side back-pressure, also on the falling edge.
  always @(negedge clk) begin
    out_stall <= rst_n && !calm_window() && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Monitor: sample both channels at the rising edge, predict and check.
  always @(posedge clk) begin
    word_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      cyc++;
      if (out_valid && !out_stall) begin
        got_word = out_data;
        if (expected_words.size() == 0) begin
          report_mismatch("result word with nothing expected", 64'(got_word), 64'(0));
        end else begin
          want_word = expected_words.pop_front();
          if (got_word.status != want_word.status) begin
            report_mismatch("status", 64'(got_word.status), 64'(want_word.status));
          end
          if (got_word.result_value != want_word.result_value) begin
            report_mismatch("result_value", 64'(got_word.result_value),
                            64'(want_word.result_value));
          end
          if (got_word.length != want_word.length) begin
            report_mismatch("length", 64'(got_word.length), 64'(want_word.length));
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_words.push_back(deque_predict(in_data));
      end
    end
  end

  // Stimulus build, reset, and end of run.
  initial begin : stimulus
    int                rand_count;
    int                mode;
    int                pick;
    int                push_pct;
    int                pop_pct;
    logic [CMD_W-1:0]  c;
    logic [VAL_W-1:0]  val;
    logic [POS_W-1:0]  pos;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    word_taken = 1'b0;
    fail_count = 0;
    cyc        = 0;
    gen_len    = 0;
    head_slot  = 0;
    held       = 0;
    flipped    = 1'b0;
    ring_vals  = '{default: '0};

    // Directed: empty-deque corners, zero handles, extremes, reversal, no-ops.
    queue_word(CMD_REVERSE,    '0,            '0, 1'b0);  // reverse while empty
    queue_word(CMD_POP_BACK,   '0,            '0, 1'b0);  // empty
    queue_word(CMD_POP_FRONT,  '0,            '0, 1'b0);  // empty
    queue_word(CMD_READ_POS,   '0,            5'd1, 1'b0);
    queue_word(CMD_PUSH_BACK,  '0,            '0, 1'b0);  // zero refused
    queue_word(CMD_PUSH_FRONT, '0,            '1, 1'b0);  // zero refused
    queue_word(CMD_PUSH_BACK,  '1,            '0, 1'b0);
    queue_word(CMD_PUSH_FRONT, 32'h0000_0001, '1, 1'b0);
    queue_word(CMD_PUSH_BACK,  32'h8000_0000, '0, 1'b0);
    queue_word(CMD_READ_POS,   '1,            '0, 1'b0);  // position zero
    queue_word(CMD_READ_POS,   '0,            5'd1, 1'b0);
    queue_word(CMD_READ_POS,   '0,            5'd3, 1'b0);
    queue_word(CMD_READ_POS,   '0,            5'd4, 1'b0);  // one past the end
    queue_word(CMD_READ_POS,   '0,            '1, 1'b0);    // field maximum
    queue_word(CMD_REVERSE,    '0,            '0, 1'b0);
    queue_word(CMD_READ_POS,   '0,            5'd1, 1'b0);
    queue_word(CMD_READ_POS,   '0,            5'd3, 1'b0);
    queue_word(CMD_SPARE6,     '1,            '1, 1'b0);
    queue_word(CMD_SPARE7,     '1,            '1, 1'b0);
    queue_word(CMD_POP_FRONT,  '0,            '0, 1'b0);
    queue_word(CMD_POP_BACK,   '0,            '0, 1'b0);
    queue_word(CMD_REVERSE,    '0,            '0, 1'b0);
    queue_word(CMD_POP_FRONT,  '0,            '0, 1'b0);
    queue_word(CMD_POP_FRONT,  '0,            '0, 1'b0);  // empty again

    // Random: bursts with a fill/drain/mixed bias so the deque swings between
    // empty and full; a small share of raw noise covers every field value.
    rand_count = 0;
    while (rand_count < RAND_ITEMS) begin
      mode = $urandom_range(MODE_FILL, MODE_MIXED);
      case (mode)
        MODE_FILL:  begin push_pct = 70; pop_pct = 10; end
        MODE_DRAIN: begin push_pct = 10; pop_pct = 70; end
        default:    begin push_pct = 35; pop_pct = 30; end
      endcase
      repeat ($urandom_range(4, 40)) begin
        val = $urandom;
        if (val == '0) begin
          val = 32'h0000_0001;
        end
        pos = '0;
        if ($urandom_range(0, 99) < 8) begin
          c   = CMD_W'($urandom_range(0, 7));
          val = ($urandom_range(0, 9) == 0) ? '0 : $urandom;
          pos = POS_W'($urandom_range(0, 31));
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < push_pct) begin
            c = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
          end else if (pick < push_pct + pop_pct) begin
            c = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
          end else if (pick < 95) begin
            c   = CMD_READ_POS;
            pos = POS_W'($urandom_range(0, gen_len + 1));
          end else begin
            c = CMD_REVERSE;
          end
        end
        // a few words wait until every result is back
        queue_word(c, val, pos, (rand_count % 500) == 250);
        if (c != CMD_SPARE6 && c != CMD_SPARE7) begin
          rand_count++;
        end
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (cmd_backlog.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (expected_words.size() != 0) begin
      @(posedge clk);
    end
    // catch stray results after the last expected one
    repeat (TAIL_WAIT) @(posedge clk);
    if (expected_words.size() != 0) begin
      report_mismatch("results never delivered", 64'(expected_words.size()), 64'(0));
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
